// ===== rtl/tqm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqm_pkg
// Shared types, codes and constants of the timer queue manager.
// ----------------------------------------------------------------------------
package tqm_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 16;
  localparam logic [31:0] WAIT_RESET = 32'd10;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] K_STARTED  = 3'd0;
  localparam logic [2:0] K_FULL     = 3'd1;
  localparam logic [2:0] K_STOPPED  = 3'd2;
  localparam logic [2:0] K_NOTFOUND = 3'd3;
  localparam logic [2:0] K_FIRED    = 3'd4;
  localparam logic [2:0] K_NONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] delay;
    logic [15:0] period;
    logic [15:0] timer_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_handle;
    logic        periodic;
    logic [31:0] next_wait;
    logic        last;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_clr;   // reset scan index and found flag
    logic scan_step;  // examine one slot
    logic do_start;
    logic do_stop;
    logic do_fire;
    logic do_tick;    // advance time
    logic wait_clr;   // reset wait scan
    logic wait_step;
    logic wait_fin;   // commit wait_hold
    logic emit;
    logic [2:0] kind;
    logic last;
  } tqm_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic wait_done;
    logic [1:0] op;
  } tqm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/tqm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqm_datapath
// Slot table, time and sequence registers, slot scanner and wait tracker.
// ----------------------------------------------------------------------------
module tqm_datapath #(
  parameter int SLOTS     = tqm_pkg::SLOTS_DEF,
  parameter int TIME_BITS = tqm_pkg::TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tqm_pkg::in_item_t  in_item,
  input  wire tqm_pkg::tqm_cmd_t  cmd,
  output tqm_pkg::tqm_stat_t      stat,
  output tqm_pkg::out_item_t      res
);
  import tqm_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [TIME_BITS-1:0] deadline [SLOTS];
  logic [15:0]          per_r    [SLOTS];
  logic [15:0]          hnd_r    [SLOTS];
  logic [15:0]          ord_r    [SLOTS];
  logic [SLOTS-1:0]     valid;

  logic [TIME_BITS-1:0] now_time;
  logic [15:0]          sequence_r;
  logic [31:0]          wait_hold;
  in_item_t             item;

  logic [CW-1:0] idx;
  logic          found;
  logic [IW-1:0] best;
  logic [CW-1:0] widx;
  logic          wfound;
  logic [IW-1:0] wbest;
  logic [15:0]   r_handle;
  logic          r_per;

  logic [IW-1:0] cur, wcur;
  assign cur  = idx[IW-1:0];
  assign wcur = widx[IW-1:0];

  logic [15:0] seq_inc;
  assign seq_inc = (sequence_r + 16'd1 == 16'd0) ? 16'd1 : sequence_r + 16'd1;

  function automatic logic before_f(logic [TIME_BITS-1:0] da, logic [15:0] oa,
                                    logic [TIME_BITS-1:0] db, logic [15:0] ob);
    logic [TIME_BITS-1:0] dd;
    logic [15:0] od;
    dd = da - db;
    od = oa - ob;
    if (da != db) return dd[TIME_BITS-1];
    return od[15];
  endfunction

  // per-slot candidate test for the current op
  logic cand;
  logic [TIME_BITS-1:0] due_d;
  always_comb begin
    due_d = now_time - deadline[cur];
    cand  = 1'b0;
    unique case (item.op)
      OP_START: cand = !valid[cur];
      OP_STOP:  cand = valid[cur] && (hnd_r[cur] == item.timer_handle);
      default:  cand = valid[cur] && !due_d[TIME_BITS-1];
    endcase
  end

  logic take;
  always_comb begin
    if (item.op == OP_TICK)
      take = cand && (!found || before_f(deadline[cur], ord_r[cur],
                                         deadline[best], ord_r[best]));
    else
      take = cand && !found;
  end

  logic [TIME_BITS-1:0] wd;
  logic [31:0] wval;
  always_comb begin
    wd = deadline[wbest] - now_time;
    if (wd[TIME_BITS-1]) wval = 32'd0;
    else if (TIME_BITS > 33 && (wd >> 32) != '0) wval = 32'hFFFF_FFFF;
    else wval = 32'(wd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      now_time   <= '0;
      sequence_r <= '0;
      wait_hold  <= WAIT_RESET;
      idx <= '0; found <= 1'b0; widx <= '0; wfound <= 1'b0;
    end else begin
      if (cmd.load) item <= in_item;
      if (cmd.do_tick) now_time <= now_time + 1'b1;
      if (cmd.scan_clr) begin
        idx <= '0; found <= 1'b0;
      end else if (cmd.scan_step && idx != SLOTS_C) begin
        if (take) begin
          best <= cur; found <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      if (cmd.do_start) begin
        valid[best]    <= 1'b1;
        deadline[best] <= now_time + TIME_BITS'(item.delay);
        per_r[best]    <= item.period;
        hnd_r[best]    <= seq_inc;
        ord_r[best]    <= seq_inc;
        sequence_r     <= seq_inc;
        r_handle <= seq_inc; r_per <= item.period != 16'd0;
      end
      if (cmd.do_stop) begin
        valid[best] <= 1'b0;
        r_handle <= item.timer_handle; r_per <= per_r[best] != 16'd0;
      end
      if (cmd.do_fire) begin
        r_handle <= hnd_r[best]; r_per <= per_r[best] != 16'd0;
        if (per_r[best] != 16'd0) begin
          deadline[best] <= deadline[best] + TIME_BITS'(per_r[best]);
          ord_r[best]    <= seq_inc;
          sequence_r     <= seq_inc;
        end else begin
          valid[best] <= 1'b0;
        end
      end
      if (cmd.wait_clr) begin
        widx <= '0; wfound <= 1'b0;
      end else if (cmd.wait_step && widx != SLOTS_C) begin
        if (valid[wcur] && (!wfound || before_f(deadline[wcur], ord_r[wcur],
                                                deadline[wbest], ord_r[wbest]))) begin
          wbest <= wcur; wfound <= 1'b1;
        end
        widx <= widx + 1'b1;
      end
      if (cmd.wait_fin && wfound) wait_hold <= wval;
    end
  end

  assign stat.scan_done = (idx == SLOTS_C);
  assign stat.found     = found;
  assign stat.wait_done = (widx == SLOTS_C);
  assign stat.op        = item.op;

  always_comb begin
    res.kind       = cmd.kind;
    res.out_handle = (cmd.kind == K_STARTED || cmd.kind == K_STOPPED ||
                      cmd.kind == K_FIRED) ? r_handle : 16'd0;
    res.periodic   = (cmd.kind == K_STARTED || cmd.kind == K_STOPPED ||
                      cmd.kind == K_FIRED) ? r_per : 1'b0;
    res.next_wait  = wait_hold;
    res.last       = cmd.last;
  end
endmodule
`default_nettype wire

// ===== rtl/tqm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqm_ctrl
// Sequencer: scan, act, rescan for the wait, look ahead, emit results.
// ----------------------------------------------------------------------------
module tqm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  output logic                   in_ready,
  input  wire tqm_pkg::tqm_stat_t stat,
  output tqm_pkg::tqm_cmd_t       cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic                   out_last
);
  import tqm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] kind, kind_next;
  logic [4:0] nres, nres_next;
  logic       more, more_next;  // tick may fire again

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_kind  = kind;
  assign out_last  = !more;

  always_comb begin
    state_next = state; kind_next = kind; nres_next = nres; more_next = more;
    cmd = '0;
    cmd.kind = kind;
    cmd.last = !more;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1; cmd.scan_clr = 1'b1; nres_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (nres == '0 && stat.op == OP_TICK && !stat.scan_done && !more) begin
          cmd.do_tick = 1'b1; more_next = 1'b1;  // first pass of a tick
        end else if (stat.op == OP_TICK || stat.op == OP_START ||
                     stat.op == OP_STOP) begin
          if (stat.scan_done) begin
            if (stat.op == OP_TICK && nres != '0) begin
              // look-ahead pass: another due timer means this result is not last, unless MAX_RESULTS are out
              more_next  = stat.found && (nres != 5'(MAX_RESULTS));
              state_next = S_OUT;
            end else state_next = S_ACT;
          end else cmd.scan_step = 1'b1;
        end else begin
          kind_next = K_NONE; more_next = 1'b0; state_next = S_OUT;
        end
      end
      S_ACT: begin
        cmd.wait_clr = 1'b1;
        state_next = S_WAIT;
        more_next = 1'b0;
        priority case (1'b1)
          stat.op == OP_START && stat.found: begin
            cmd.do_start = 1'b1; kind_next = K_STARTED;
          end
          stat.op == OP_START: begin
            kind_next = K_FULL; state_next = S_OUT;
          end
          stat.op == OP_STOP && stat.found: begin
            cmd.do_stop = 1'b1; kind_next = K_STOPPED;
          end
          stat.op == OP_STOP: begin
            kind_next = K_NOTFOUND; state_next = S_OUT;
          end
          stat.found: begin
            cmd.do_fire = 1'b1; kind_next = K_FIRED;
            nres_next = nres + 5'd1;
          end
          default: kind_next = K_NONE;
        endcase
      end
      S_WAIT: begin
        if (stat.wait_done) begin
          cmd.wait_fin = 1'b1;
          if (stat.op == OP_TICK && nres != '0) begin
            cmd.scan_clr = 1'b1; state_next = S_SCAN;
          end else state_next = S_OUT;
        end else cmd.wait_step = 1'b1;
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        if (out_ready) begin
          if (more) state_next = S_ACT;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; kind <= K_NONE; nres <= '0; more <= 1'b0;
    end else begin
      state <= state_next; kind <= kind_next; nres <= nres_next; more <= more_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/timer_queue_manager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timer_queue_manager
// Table of one-shot and periodic timers driven by start, stop and tick items.
// ----------------------------------------------------------------------------
// One item at a time. A start or stop scans all slots to pick the slot,
// takes one action step, scans again to find the earliest deadline for
// next_wait and then presents the result. A full table or a missing handle
// skips the second scan. A tick first advances time; each fired timer then
// costs the action, the wait scan and a look-ahead scan that decides whether
// the result is the last; a tick that fires nothing still does the action
// and the wait scan. Output stalls hold the result until it is taken. The
// slot scanner and wait tracker in the datapath do the scans.
module timer_queue_manager #(
  parameter int SLOTS     = tqm_pkg::SLOTS_DEF,
  parameter int TIME_BITS = tqm_pkg::TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tqm_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tqm_pkg::out_item_t      out_data
);
  import tqm_pkg::*;

  tqm_cmd_t  cmd;
  tqm_stat_t stat;
  out_item_t res;
  logic [2:0] ckind;
  logic       clast;

  // controller sequences the datapath
  tqm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .in_ready(in_ready),
    .stat(stat), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(ckind), .out_last(clast)
  );

  // datapath holds the slot table and time
  tqm_datapath #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .stat(stat), .res(res)
  );

  assign out_data = res;

  // hold a result steady until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // never accept an item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output overlap");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ckind == out_data.kind && clast == out_data.last)
    else $error("result fields mismatch controller");
endmodule
`default_nettype wire
